@@ sv/fpwf_pkg.sv @@
// ----------------------------------------------------------------------------
// fpwf_pkg
// Shared constants and types for the first positive window finder.
// ----------------------------------------------------------------------------
package fpwf_pkg;

  localparam int DATA_W      = 16;   // Q8.8 sample width
  localparam int POS_OUT_W   = 7;    // top_row / left_col width
  localparam int CFG_W       = 8;    // dimension register width
  localparam int CFG_IDX_W   = 8;    // register index width
  localparam int TDATA_OUT_W = 32;   // 31 bits of fields, padded to bytes

  localparam int MAX_DIM_DEF = 128;
  localparam int WIN_DEF     = 3;
  localparam int DIM_RESET   = 128;  // reset value of both dimension registers

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_COUNT = 8'd0,
    REG_COL_COUNT = 8'd1
  } cfg_reg_t;

  // result request from the window stage to the output emitter
  typedef struct packed {
    logic hit;    // window found: emit the whole window
    logic miss;   // matrix ended with nothing found: emit one not-found word
  } emit_req_t;

endpackage

@@ sv/fpwf_ram.sv @@
// ----------------------------------------------------------------------------
// fpwf_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module fpwf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ sv/fpwf_window.sv @@
// ----------------------------------------------------------------------------
// fpwf_window
// Window register array, line word update and all-positive check.
// ----------------------------------------------------------------------------
module fpwf_window
  import fpwf_pkg::*;
#(
  parameter int WIN = WIN_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               clear,      // config write: new matrix
  input  logic                               item_valid,
  input  logic                               go,         // item leaves the stage
  input  logic                               pos_ok,     // full window in range
  input  logic                               mat_end,    // last element of matrix
  input  logic [DATA_W-1:0]                  sample,
  input  logic [(WIN-1)*DATA_W-1:0]          line_rdata, // lane 0 = oldest row
  output logic [(WIN-1)*DATA_W-1:0]          line_wdata,
  output logic [WIN*WIN-1:0][DATA_W-1:0]     win_next,   // row-major
  output emit_req_t                          req
);

  logic [WIN*WIN-1:0][DATA_W-1:0] win;
  logic [WIN-1:0][DATA_W-1:0]     column;
  logic                           found_flag;
  logic                           found_flag_next;
  logic                           all_pos;

  always_comb begin
    for (int i = 0; i < WIN - 1; i++) begin
      column[i] = line_rdata[i*DATA_W +: DATA_W];
    end
    column[WIN-1] = sample;
    // rows move up one lane; the new sample becomes the newest lane
    for (int i = 0; i < WIN - 1; i++) begin
      line_wdata[i*DATA_W +: DATA_W] = column[i+1];
    end
  end

  always_comb begin
    for (int i = 0; i < WIN; i++) begin
      for (int j = 0; j < WIN - 1; j++) begin
        win_next[i*WIN+j] = win[i*WIN+j+1];
      end
      win_next[i*WIN+WIN-1] = column[i];
    end
  end

  always_comb begin
    all_pos = 1'b1;
    for (int i = 0; i < WIN * WIN; i++) begin
      if (win_next[i] == '0 || win_next[i][DATA_W-1]) begin
        all_pos = 1'b0;
      end
    end
  end

  assign req.hit  = item_valid && !found_flag && pos_ok && all_pos;
  assign req.miss = item_valid && mat_end && !found_flag && !req.hit;

  always_comb begin
    found_flag_next = found_flag;
    if (go) begin
      found_flag_next = mat_end ? 1'b0 : (found_flag || req.hit);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      found_flag <= 1'b0;
    end else begin
      found_flag <= found_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      win <= win_next;
    end
  end

endmodule

@@ sv/fpwf_emit.sv @@
// ----------------------------------------------------------------------------
// fpwf_emit
// Output emitter: holds one result burst and shifts it out word by word.
// ----------------------------------------------------------------------------
module fpwf_emit
  import fpwf_pkg::*;
#(
  parameter int WIN = WIN_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           load_hit,
  input  logic                           load_miss,
  input  logic [WIN*WIN-1:0][DATA_W-1:0] win,
  input  logic [POS_OUT_W-1:0]           top_row_in,
  input  logic [POS_OUT_W-1:0]           left_col_in,
  output logic                           free,       // may load this cycle
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [TDATA_OUT_W-1:0]         m_axis_tdata, // found, top_row, left_col,
                                                       // window_value, zero pad
  output logic                           m_axis_tlast
);

  localparam int NRES  = WIN * WIN;
  localparam int CNT_W = $clog2(NRES + 1);

  logic [CNT_W-1:0]            cnt;
  logic [NRES-1:0][DATA_W-1:0] vals;
  logic                        found;
  logic [POS_OUT_W-1:0]        top_row;
  logic [POS_OUT_W-1:0]        left_col;
  logic                        take;

  assign take          = m_axis_tvalid && m_axis_tready;
  assign m_axis_tvalid = (cnt != '0);
  assign m_axis_tlast  = (cnt == CNT_W'(1));
  assign free          = (cnt == '0) || (cnt == CNT_W'(1) && m_axis_tready);
  assign m_axis_tdata  = {{(TDATA_OUT_W - 1 - 2*POS_OUT_W - DATA_W){1'b0}},
                          vals[0], left_col, top_row, found};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load_hit) begin
      cnt <= CNT_W'(NRES);
    end else if (load_miss) begin
      cnt <= CNT_W'(1);
    end else if (take) begin
      cnt <= cnt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load_hit) begin
      vals     <= win;
      found    <= 1'b1;
      top_row  <= top_row_in;
      left_col <= left_col_in;
    end else if (load_miss) begin
      vals     <= '0;
      found    <= 1'b0;
      top_row  <= '0;
      left_col <= '0;
    end else if (take) begin
      for (int i = 0; i < NRES - 1; i++) begin
        vals[i] <= vals[i+1];
      end
      vals[NRES-1] <= '0;
    end
  end

endmodule

@@ sv/first_positive_window_finder.sv @@
// ----------------------------------------------------------------------------
// first_positive_window_finder
// Finds the first WIN x WIN window of all-positive Q8.8 samples in a raster
// matrix and streams out its values, or one not-found word at matrix end.
// ----------------------------------------------------------------------------
// Samples enter at one per cycle. A sample is read against the line store
// (one RAM word per column holding the WIN-1 previous rows) when it is taken,
// and, from the window stage registers, it updates the window, writes the line
// word back and is checked. Results leave through an emitter holding one
// burst: WIN*WIN words if a window is found, one if the matrix ends with none.
// Input is held off only when a sample that causes results meets a burst that
// is still draining; samples that cause no results keep flowing, one per
// cycle, during a burst. The line store needs no clearing pass after reset:
// a line word is always written within the current matrix before it can
// reach a result. A dimension register write restarts the matrix.
// ----------------------------------------------------------------------------
module first_positive_window_finder
  import fpwf_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEF,
  parameter int WIN     = WIN_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [DATA_W-1:0]      s_axis_tdata,   // sample
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [TDATA_OUT_W-1:0] m_axis_tdata,   // found, top_row, left_col,
                                                 // window_value, zero pad
  output logic                   m_axis_tlast,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data
);

  localparam int POS_W     = $clog2(MAX_DIM);
  localparam int DIM_W     = $clog2(MAX_DIM + 1);
  localparam int LINE_W    = (WIN - 1) * DATA_W;
  localparam int DIM_RST_V = (DIM_RESET > MAX_DIM) ? MAX_DIM : DIM_RESET;

  logic [DIM_W-1:0] rows_eff;
  logic [DIM_W-1:0] cols_eff;
  logic [DIM_W-1:0] cfg_eff;
  logic             cfg_we;

  logic [POS_W-1:0] row_pos;
  logic [POS_W-1:0] col_pos;
  logic [POS_W-1:0] row_pos_next;
  logic [POS_W-1:0] col_pos_next;
  logic             row_done;
  logic             mat_done;
  logic             accept;

  // window stage registers
  logic              p1_valid;
  logic [DATA_W-1:0] p1_sample;
  logic [POS_W-1:0]  p1_row;
  logic [POS_W-1:0]  p1_col;
  logic              p1_end;
  logic              p1_go;
  logic              p1_pos_ok;

  logic [LINE_W-1:0]              line_rdata;
  logic [LINE_W-1:0]              line_wdata;
  logic [WIN*WIN-1:0][DATA_W-1:0] win_next;
  emit_req_t                      req;
  logic                           emit_free;

  logic [POS_W-1:0]           top_row_full;
  logic [POS_W-1:0]           left_col_full;
  logic [POS_W+POS_OUT_W-1:0] top_row_ext;
  logic [POS_W+POS_OUT_W-1:0] left_col_ext;

  // ---------------- configuration ----------------
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_comb begin
    if (cfg_data == '0) begin
      cfg_eff = DIM_W'(1);
    end else if (32'(cfg_data) > 32'(MAX_DIM)) begin
      cfg_eff = DIM_W'(MAX_DIM);
    end else begin
      cfg_eff = DIM_W'(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_eff <= DIM_W'(DIM_RST_V);
      cols_eff <= DIM_W'(DIM_RST_V);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROW_COUNT: rows_eff <= cfg_eff;
        REG_COL_COUNT: cols_eff <= cfg_eff;
        default: ;
      endcase
    end
  end

  // ---------------- position counters ----------------
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign row_done = (DIM_W'(col_pos) + DIM_W'(1)) >= cols_eff;
  assign mat_done = row_done && ((DIM_W'(row_pos) + DIM_W'(1)) >= rows_eff);

  always_comb begin
    row_pos_next = row_pos;
    col_pos_next = col_pos;
    if (accept) begin
      if (mat_done) begin
        row_pos_next = '0;
        col_pos_next = '0;
      end else if (row_done) begin
        row_pos_next = row_pos + POS_W'(1);
        col_pos_next = '0;
      end else begin
        col_pos_next = col_pos + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      row_pos <= '0;
      col_pos <= '0;
    end else begin
      row_pos <= row_pos_next;
      col_pos <= col_pos_next;
    end
  end

  // ---------------- window stage ----------------
  assign p1_go         = p1_valid && ((!req.hit && !req.miss) || emit_free);
  assign s_axis_tready = !p1_valid || p1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      p1_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p1_sample <= s_axis_tdata;
      p1_row    <= row_pos;
      p1_col    <= col_pos;
      p1_end    <= mat_done;
    end
  end

  assign p1_pos_ok = (32'(p1_row) >= 32'(WIN - 1)) && (32'(p1_col) >= 32'(WIN - 1));

  fpwf_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_DIM)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (p1_go),
    .wr_addr (p1_col),
    .wr_data (line_wdata),
    .rd_en   (accept),
    .rd_addr (col_pos),
    .rd_data (line_rdata)
  );

  fpwf_window #(
    .WIN (WIN)
  ) u_window (
    .clk        (clk),
    .rst        (rst),
    .clear      (cfg_we),
    .item_valid (p1_valid),
    .go         (p1_go),
    .pos_ok     (p1_pos_ok),
    .mat_end    (p1_end),
    .sample     (p1_sample),
    .line_rdata (line_rdata),
    .line_wdata (line_wdata),
    .win_next   (win_next),
    .req        (req)
  );

  // top-left corner of the window, cut to the output field width
  assign top_row_full  = p1_row - POS_W'(WIN - 1);
  assign left_col_full = p1_col - POS_W'(WIN - 1);
  assign top_row_ext   = {{POS_OUT_W{1'b0}}, top_row_full};
  assign left_col_ext  = {{POS_OUT_W{1'b0}}, left_col_full};

  // ---------------- output ----------------
  fpwf_emit #(
    .WIN (WIN)
  ) u_emit (
    .clk           (clk),
    .rst           (rst),
    .load_hit      (p1_go && req.hit),
    .load_miss     (p1_go && req.miss),
    .win           (win_next),
    .top_row_in    (top_row_ext[POS_OUT_W-1:0]),
    .left_col_in   (left_col_ext[POS_OUT_W-1:0]),
    .free          (emit_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

@@ tb/first_positive_window_finder_test.sv @@
// ----------------------------------------------------------------------------
// first_positive_window_finder_test
// Self-checking bench for the first all-positive 3x3 window search.
// ----------------------------------------------------------------------------
// Streams matrices of Q8.8 samples through the block under random valid and
// ready idling, predicts every result word in a cycle-free scoreboard model
// and checks each word field by field in arrival order. Dimension registers
// are rewritten between phases once the block has drained. The stimulus
// covers small, degenerate and full-width matrices, planted windows, noise,
// out-of-range register values and writes to unused register indexes.
// ----------------------------------------------------------------------------
module first_positive_window_finder_test;
  import fpwf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = 8;     // quiet cycles before a register write
  localparam int STALL_LIMIT   = 1000;  // cycles with no word moved on any port
  localparam int TAIL_ITEMS    = 60;    // last samples run with no idling
  localparam int LINES         = WIN_DEF - 1;

  localparam logic [CFG_IDX_W-1:0] IDX_SPARE = 8'd2;
  localparam logic [CFG_IDX_W-1:0] IDX_TOP   = 8'd255;

  typedef enum logic [1:0] {OP_SAMPLE, OP_CFG, OP_DRAIN} op_kind_t;
  typedef enum logic [1:0] {FILL_POSITIVE, FILL_SPARSE_HOLES, FILL_PLANTED,
                            FILL_NOISE} fill_t;

  typedef struct {
    op_kind_t              kind;
    logic [DATA_W-1:0]     value;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_W-1:0]      data;
  } feed_t;

  typedef struct packed {
    logic                  last;
    logic [DATA_W-1:0]     value;
    logic [POS_OUT_W-1:0]  left_col;
    logic [POS_OUT_W-1:0]  top_row;
    logic                  found;
  } win_word_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [DATA_W-1:0]      s_axis_tdata = '0;      // sample
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [TDATA_OUT_W-1:0] m_axis_tdata;           // found, top_row, left_col,
                                                  // window_value, zero pad
  logic                   m_axis_tlast;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_W-1:0]       cfg_data = '0;

  first_positive_window_finder dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // scoreboard model state
  logic [DATA_W-1:0] line_mem [LINES][MAX_DIM_DEF];
  logic [DATA_W-1:0] win_q [WIN_DEF*WIN_DEF];
  int unsigned       row_at, col_at;
  bit                hit_done;
  logic [CFG_W-1:0]  rows_reg = CFG_W'(DIM_RESET);
  logic [CFG_W-1:0]  cols_reg = CFG_W'(DIM_RESET);

  win_word_t results_due [$];
  feed_t     pending [$];

  int queued_samples, samples_sent, words_seen, reg_writes, drains_done;
  int matrices_done, windows_seen, misses_seen, mismatches;
  int calm_from = 32'h7fff_ffff;
  bit calm_tail;
  int gap_left, settle, stall_left, quiet_cycles;

  initial begin
    foreach (line_mem[i, j]) line_mem[i][j] = '0;
    foreach (win_q[k]) win_q[k] = '0;
  end

  function automatic int unsigned dim_of(logic [CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM_DEF) return MAX_DIM_DEF;
    return v;
  endfunction

  function automatic void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    case (idx)
      REG_ROW_COUNT: rows_reg = data;
      REG_COL_COUNT: cols_reg = data;
      default: ;
    endcase
    // any write starts a new matrix
    row_at = 0;
    col_at = 0;
    hit_done = 1'b0;
  endfunction

  function automatic void scan_sample(logic [DATA_W-1:0] s);
    int unsigned rows, cols, ci;
    logic [DATA_W-1:0] col_in [WIN_DEF];
    bit all_pos;
    win_word_t w;
    rows = dim_of(rows_reg);
    cols = dim_of(cols_reg);
    ci = (col_at < MAX_DIM_DEF) ? col_at : MAX_DIM_DEF - 1;
    for (int i = 0; i < LINES; i++) col_in[i] = line_mem[(row_at + i) % LINES][ci];
    col_in[WIN_DEF-1] = s;
    line_mem[row_at % LINES][ci] = s;
    for (int i = 0; i < WIN_DEF; i++) begin
      for (int j = 0; j < WIN_DEF - 1; j++) win_q[i*WIN_DEF+j] = win_q[i*WIN_DEF+j+1];
      win_q[i*WIN_DEF+WIN_DEF-1] = col_in[i];
    end
    if (!hit_done && row_at >= WIN_DEF - 1 && col_at >= WIN_DEF - 1) begin
      all_pos = 1'b1;
      foreach (win_q[k]) if (!($signed(win_q[k]) > 0)) all_pos = 1'b0;
      if (all_pos) begin
        for (int k = 0; k < WIN_DEF * WIN_DEF; k++) begin
          w.found    = 1'b1;
          w.top_row  = POS_OUT_W'(row_at - (WIN_DEF - 1));
          w.left_col = POS_OUT_W'(col_at - (WIN_DEF - 1));
          w.value    = win_q[k];
          w.last     = (k == WIN_DEF * WIN_DEF - 1);
          results_due.push_back(w);
        end
        hit_done = 1'b1;
        windows_seen++;
      end
    end
    if (col_at + 1 >= cols) begin
      if (row_at + 1 >= rows) begin
        if (!hit_done) begin
          w = '0;
          w.last = 1'b1;
          results_due.push_back(w);
          misses_seen++;
        end
        row_at = 0;
        col_at = 0;
        hit_done = 1'b0;
        matrices_done++;
      end else begin
        row_at++;
        col_at = 0;
      end
    end else begin
      col_at++;
    end
  endfunction

  function automatic string word_text(win_word_t w);
    return $sformatf("found=%0d top_row=%0d left_col=%0d value=%h last=%0d",
                     w.found, w.top_row, w.left_col, w.value, w.last);
  endfunction

  function automatic void log_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $realtime, msg);
  endfunction

  // ---- stimulus queue builders ----
  task automatic push_sample(logic [DATA_W-1:0] v);
    pending.push_back('{OP_SAMPLE, v, '0, '0});
    queued_samples++;
  endtask

  task automatic push_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    pending.push_back('{OP_CFG, '0, idx, data});
  endtask

  task automatic push_drain();
    pending.push_back('{OP_DRAIN, '0, '0, '0});
  endtask

  function automatic logic [DATA_W-1:0] pos_word();
    case ($urandom_range(0, 5))
      0: return 16'h0001;
      1: return 16'h7fff;
      default: return 16'($urandom_range(1, 32767));
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] nonpos_word();
    case ($urandom_range(0, 4))
      0: return 16'h0000;
      1: return 16'h8000;
      2: return 16'hffff;
      default: return {1'b1, 15'($urandom)};
    endcase
  endfunction

  function automatic int pick_dim();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 9);
  endfunction

  task automatic push_matrix(int rows, int cols);
    fill_t fill;
    int pr, pc;
    bit inside_plant;
    logic [DATA_W-1:0] v;
    fill = fill_t'($urandom_range(0, 3));
    pr = $urandom_range(0, (rows >= 3) ? rows - 3 : 0);
    pc = $urandom_range(0, (cols >= 3) ? cols - 3 : 0);
    for (int r = 0; r < rows; r++) begin
      for (int c = 0; c < cols; c++) begin
        inside_plant = (r >= pr && r < pr + 3 && c >= pc && c < pc + 3);
        case (fill)
          FILL_POSITIVE:     v = pos_word();
          FILL_SPARSE_HOLES: v = ($urandom_range(0, 15) == 0) ? nonpos_word() : pos_word();
          FILL_PLANTED:      v = (inside_plant || $urandom_range(0, 1)) ? pos_word()
                                                                        : nonpos_word();
          default:           v = 16'($urandom);
        endcase
        push_sample(v);
      end
    end
  endtask

  // ---- sample and register driver ----
  always @(posedge clk) begin
    logic nxt_valid, nxt_cfg;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      cfg_valid <= 1'b0;
      gap_left = 0;
      settle = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        scan_sample(s_axis_tdata);
        samples_sent++;
      end
      if (cfg_valid && cfg_ready) begin
        write_reg(cfg_index, cfg_data);
        reg_writes++;
      end
      if (results_due.size() != 0 || m_axis_tvalid || (s_axis_tvalid && s_axis_tready))
        settle = 0;
      else
        settle++;
      calm_tail = (samples_sent >= calm_from);
      nxt_valid = s_axis_tvalid && !s_axis_tready;
      nxt_cfg = cfg_valid && !cfg_ready;
      if (!nxt_valid && !nxt_cfg) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending.size() != 0) begin
          case (pending[0].kind)
            OP_SAMPLE: begin
              s_axis_tdata <= pending[0].value;
              nxt_valid = 1'b1;
              void'(pending.pop_front());
              if (!calm_tail && $urandom_range(0, 9) == 0) gap_left = $urandom_range(1, 14);
            end
            OP_CFG: if (settle >= SETTLE_CYCLES) begin
              cfg_index <= pending[0].idx;
              cfg_data <= pending[0].data;
              nxt_cfg = 1'b1;
              void'(pending.pop_front());
              settle = 0;
            end
            OP_DRAIN: if (settle >= SETTLE_CYCLES) begin
              void'(pending.pop_front());
              drains_done++;
            end
            default: ;
          endcase
        end
      end
      s_axis_tvalid <= nxt_valid;
      cfg_valid <= nxt_cfg;
    end
  end

  // ---- result monitor ----
  always @(posedge clk) begin
    win_word_t got, want;
    logic rdy;
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.found    = m_axis_tdata[0];
        got.top_row  = m_axis_tdata[7:1];
        got.left_col = m_axis_tdata[14:8];
        got.value    = m_axis_tdata[30:15];
        got.last     = m_axis_tlast;
        words_seen++;
        if (results_due.size() == 0) begin
          log_mismatch({"unexpected word: ", word_text(got)});
        end else begin
          want = results_due.pop_front();
          if (got.found !== want.found || got.top_row !== want.top_row ||
              got.left_col !== want.left_col || got.value !== want.value ||
              got.last !== want.last)
            log_mismatch({"expected ", word_text(want), " / got ", word_text(got)});
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        rdy = 1'b0;
      end else if (!calm_tail && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 13);
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
      end
      m_axis_tready <= rdy;
    end
  end

  // ---- watchdog ----
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("no word moved for %0d cycles, %0d results still due",
                 STALL_LIMIT, results_due.size());
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    int rows, cols, base;

    // all positive, extremes included: window found on the final element
    push_cfg(REG_ROW_COUNT, 8'd3);
    push_cfg(REG_COL_COUNT, 8'd3);
    push_sample(16'h7fff); push_sample(16'h0001); push_sample(16'h0100);
    push_sample(16'h4000); push_sample(16'h7fff); push_sample(16'h0001);
    push_sample(16'h1234); push_sample(16'h00ff); push_sample(16'h7fff);
    // partial matrix, drain, then a write to an unused index restarts it
    push_sample(16'h8000); push_sample(16'hffff); push_sample(16'h0000);
    push_sample(16'h8001);
    push_drain();
    push_cfg(IDX_SPARE, 8'ha5);
    // zero, most negative and minus one spoil the only window
    push_sample(16'h0001); push_sample(16'h8000); push_sample(16'h0100);
    push_sample(16'h0000); push_sample(16'h7fff); push_sample(16'hffff);
    push_sample(16'h2000); push_sample(16'h0001); push_sample(16'h7fff);
    // zero dimension reads as one: 1x2 and 1x1 matrices never hold a window
    push_cfg(REG_ROW_COUNT, 8'd0);
    push_cfg(REG_COL_COUNT, 8'd2);
    push_sample(16'h7fff); push_sample(16'h0001);
    push_cfg(REG_COL_COUNT, 8'd0);
    push_sample(16'h0001);

    // full-width row, with an oversized column count saturating
    push_cfg(REG_ROW_COUNT, 8'd1);
    push_cfg(REG_COL_COUNT, 8'd200);
    push_matrix(1, 128);
    push_cfg(IDX_TOP, 8'hff);

    base = queued_samples;
    while (queued_samples - base < 130) begin
      rows = pick_dim();
      cols = pick_dim();
      if ($urandom_range(0, 1)) begin
        push_cfg(REG_ROW_COUNT, (rows == 1 && $urandom_range(0, 1)) ? 8'd0 : CFG_W'(rows));
        push_cfg(REG_COL_COUNT, CFG_W'(cols));
      end else begin
        push_cfg(REG_COL_COUNT, (cols == 1 && $urandom_range(0, 1)) ? 8'd0 : CFG_W'(cols));
        push_cfg(REG_ROW_COUNT, CFG_W'(rows));
      end
      if ($urandom_range(0, 5) == 0) push_cfg(CFG_IDX_W'($urandom_range(2, 255)), CFG_W'($urandom));
      repeat ($urandom_range(1, 3)) push_matrix(rows, cols);
      if ($urandom_range(0, 3) == 0) push_drain();
    end
    calm_from = queued_samples - TAIL_ITEMS;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (pending.size() != 0 || s_axis_tvalid || cfg_valid || results_due.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);

    $display("%0d matrices from %0d samples, %0d register writes, %0d drain pauses",
             matrices_done, samples_sent, reg_writes, drains_done);
    $display("%0d windows found, %0d empty matrices, %0d result words, %0d mismatches",
             windows_seen, misses_seen, words_seen, mismatches);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/fpwf_pkg.sv
sv/fpwf_ram.sv
sv/fpwf_window.sv
sv/fpwf_emit.sv
sv/first_positive_window_finder.sv
tb/first_positive_window_finder_test.sv
